// ----- rtl/jlsv_pkg.sv -----
// shared widths and defaults for the jerk limited stop velocity pass
// no dependencies
`timescale 1ns / 1ps
package jlsv_pkg;
  localparam int POS_W         = 32;
  localparam int SPEED_W       = 24;
  localparam int CFG_W         = 23;
  localparam int FRAC_BITS_DEF = 16;
  localparam logic [CFG_W-1:0] JERK_RESET  = 23'd65536;
  localparam logic [CFG_W-1:0] DECEL_RESET = 23'd65536;
endpackage

// ----- rtl/jlsv_point_if.sv -----
// point and result channels with valid/ready handshake
// depends on jlsv_pkg
`timescale 1ns / 1ps
interface jlsv_point_if import jlsv_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [POS_W-1:0]   pos_x;
  logic signed [POS_W-1:0]   pos_y;
  logic signed [SPEED_W-1:0] speed_in;
  logic signed [SPEED_W-1:0] accel_in;
  logic                      is_stop_point;
  modport source (output valid, pos_x, pos_y, speed_in, accel_in, is_stop_point,
                  input ready);
  modport sink (input valid, pos_x, pos_y, speed_in, accel_in, is_stop_point,
                output ready);
endinterface

interface jlsv_result_if import jlsv_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] speed_out;
  logic signed [SPEED_W-1:0] accel_out;
  logic                      was_updated;
  modport source (output valid, speed_out, accel_out, was_updated, input ready);
  modport sink (input valid, speed_out, accel_out, was_updated, output ready);
endinterface

// ----- rtl/jerk_limited_stop_velocity_pass.sv -----
// top level of the jerk limited stop velocity pass
// depends on jlsv_pkg and the channel interfaces in jlsv_point_if.sv
`timescale 1ns / 1ps
// Points arrive in reverse order; a stop point leaves at once with zero speed and
// acceleration, while a point that comes while no pass is active passes through at once
// unchanged. A point inside an active pass is worked out by one shared 32x32 multiplier, a
// one-bit-a-cycle square root unit and a one-bit-a-cycle divider under a small sequencer:
// eight multiply, add or select steps, two square roots, an overflow check, a divide
// (skipped when the quotient surely hits the cap) and a result step, plus any wait for the
// result register to empty. The block takes no point meanwhile. pready is always high;
// registers sit at byte addresses 0, 4.
module jerk_limited_stop_velocity_pass import jlsv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  jlsv_point_if.sink         points,
  jlsv_result_if.source      results
);
  localparam logic [CFG_W-1:0] MIN_SPEED = CFG_W'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic [CFG_W-1:0] SPEED_MAX = {CFG_W{1'b1}};

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MULX  = 4'd1;
  localparam logic [3:0] S_MULY  = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_SQRT  = 4'd4;
  localparam logic [3:0] S_MULJ  = 4'd5;
  localparam logic [3:0] S_DCHK  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_ASEL  = 4'd8;
  localparam logic [3:0] S_MULV  = 4'd9;
  localparam logic [3:0] S_MULS  = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0] state;
  logic [CFG_W-1:0] jerk_max, decel_limit;
  logic signed [POS_W-1:0] ref_x, ref_y;
  logic [SPEED_W-1:0] ref_speed, ref_accel_mag;
  logic pass_active;

  // latched point
  logic signed [POS_W-1:0] px, py;
  logic signed [SPEED_W-1:0] spd;
  // point acceleration kept for pass-through at pass end
  logic signed [SPEED_W-1:0] acc_in_hold;

  logic [30:0] dx, dy;
  logic [31:0] ds;
  logic        second;
  logic [63:0] prod, acc;
  logic [31:0] mul_a, mul_b;
  logic [63:0] sq_rad;
  logic [33:0] sq_rem;
  logic [31:0] sq_root;
  logic [4:0]  cnt;
  logic [CFG_W-1:0] dv_d, dv_rem;
  logic [23:0] dv_low, dv_q;
  logic        dv_ovf;
  logic [CFG_W-1:0] a_mag;

  logic out_free;
  assign out_free = !results.valid || results.ready;
  assign points.ready = (state == S_IDLE) && out_free;
  assign pready = 1'b1;

  // a result word is loaded on a stop point, a direct pass-through or at the end of the sequence
  logic res_load;
  assign res_load = ((state == S_IDLE) && points.valid && points.ready &&
                     (points.is_stop_point || !pass_active)) ||
                    ((state == S_FIN) && out_free);

  // apb
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    prdata = {9'd0, paddr[2] ? decel_limit : jerk_max};
  end

  // saturated absolute differences
  logic signed [POS_W:0] diff_x, diff_y;
  logic [POS_W:0] mag_x, mag_y;
  assign diff_x = {points.pos_x[POS_W-1], points.pos_x} - {ref_x[POS_W-1], ref_x};
  assign diff_y = {points.pos_y[POS_W-1], points.pos_y} - {ref_y[POS_W-1], ref_y};
  assign mag_x = diff_x[POS_W] ? (POS_W+1)'(-diff_x) : diff_x;
  assign mag_y = diff_y[POS_W] ? (POS_W+1)'(-diff_y) : diff_y;

  // shared multiplier
  always_comb begin
    unique case (state)
      S_MULX:  begin mul_a = {1'b0, dx}; mul_b = {1'b0, dx}; end
      S_MULY:  begin mul_a = {1'b0, dy}; mul_b = {1'b0, dy}; end
      S_MULJ:  begin mul_a = {9'd0, jerk_max}; mul_b = sq_root; end
      S_MULV:  begin mul_a = {8'd0, ref_speed}; mul_b = {8'd0, ref_speed}; end
      S_MULS:  begin
        mul_a = {8'd0, ref_accel_mag + {1'b0, a_mag}};
        mul_b = ds;
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // one root bit per cycle
  logic [33:0] sq_t, sq_trial;
  logic        sq_ge;
  assign sq_t     = {sq_rem[31:0], sq_rad[63:62]};
  assign sq_trial = {sq_root, 2'b01};
  assign sq_ge    = sq_t >= sq_trial;

  // one quotient bit per cycle
  logic [CFG_W:0] dv_t;
  logic           dv_ge;
  assign dv_t  = {dv_rem, dv_low[23]};
  assign dv_ge = dv_t >= {1'b0, dv_d};

  logic [24:0] a_sum;
  assign a_sum = {1'b0, ref_accel_mag} + {1'b0, dv_q};

  logic [CFG_W-1:0] v_sat;
  logic             v_lower;
  assign v_sat   = (sq_root[31:CFG_W] != '0) ? SPEED_MAX : sq_root[CFG_W-1:0];
  assign v_lower = !spd[SPEED_W-1] && (v_sat < spd[CFG_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      jerk_max      <= JERK_RESET;
      decel_limit   <= DECEL_RESET;
      ref_x         <= '0;
      ref_y         <= '0;
      ref_speed     <= '0;
      ref_accel_mag <= '0;
      pass_active   <= 1'b0;
      results.valid <= 1'b0;
      cnt           <= '0;
      second        <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2]) decel_limit <= pwdata[CFG_W-1:0];
        else jerk_max <= pwdata[CFG_W-1:0];
      end
      if (res_load) results.valid <= 1'b1;
      else if (results.valid && results.ready) results.valid <= 1'b0;
      prod <= mul_a * mul_b;

      unique case (state)
        S_IDLE: begin
          if (points.valid && points.ready) begin
            px  <= points.pos_x;
            py  <= points.pos_y;
            spd <= points.speed_in;
            dx  <= (mag_x > 33'h7FFFFFFF) ? 31'h7FFFFFFF : mag_x[30:0];
            dy  <= (mag_y > 33'h7FFFFFFF) ? 31'h7FFFFFFF : mag_y[30:0];
            if (points.is_stop_point) begin
              ref_x         <= points.pos_x;
              ref_y         <= points.pos_y;
              ref_speed     <= '0;
              ref_accel_mag <= '0;
              pass_active   <= 1'b1;
              results.speed_out   <= '0;
              results.accel_out   <= '0;
              results.was_updated <= 1'b1;
            end else if (!pass_active) begin
              results.speed_out   <= points.speed_in;
              results.accel_out   <= points.accel_in;
              results.was_updated <= 1'b0;
            end else begin
              state <= S_MULX;
            end
          end
        end
        S_MULX: state <= S_MULY;
        S_MULY: begin
          acc   <= prod;
          state <= S_SUM;
        end
        S_SUM: begin
          sq_rad  <= acc + prod;
          sq_rem  <= '0;
          sq_root <= '0;
          cnt     <= '0;
          state   <= S_SQRT;
        end
        S_SQRT: begin
          sq_rad  <= {sq_rad[61:0], 2'b00};
          sq_rem  <= sq_ge ? sq_t - sq_trial : sq_t;
          sq_root <= {sq_root[30:0], sq_ge};
          cnt     <= cnt + 5'd1;
          if (cnt == 5'd31) state <= second ? S_FIN : S_MULJ;
        end
        S_MULJ: begin
          ds    <= sq_root;
          dv_d  <= (ref_speed[CFG_W-1:0] > MIN_SPEED) ? ref_speed[CFG_W-1:0] : MIN_SPEED;
          state <= S_DCHK;
        end
        S_DCHK: begin
          // quotient of 2^24 or more always hits the cap
          dv_ovf <= prod >= {17'd0, dv_d, 24'd0};
          dv_rem <= prod[46:24];
          dv_low <= prod[23:0];
          dv_q   <= '0;
          cnt    <= '0;
          state  <= (prod >= {17'd0, dv_d, 24'd0}) ? S_ASEL : S_DIV;
        end
        S_DIV: begin
          dv_rem <= dv_ge ? CFG_W'(dv_t - {1'b0, dv_d}) : dv_t[CFG_W-1:0];
          dv_low <= {dv_low[22:0], 1'b0};
          dv_q   <= {dv_q[22:0], dv_ge};
          cnt    <= cnt + 5'd1;
          if (cnt == 5'd23) state <= S_ASEL;
        end
        S_ASEL: begin
          a_mag <= (dv_ovf || a_sum > {2'b00, decel_limit}) ? decel_limit : a_sum[CFG_W-1:0];
          state <= S_MULV;
        end
        S_MULV: state <= S_MULS;
        S_MULS: begin
          acc    <= prod;
          second <= 1'b1;
          state  <= S_SUM;
        end
        S_FIN: begin
          if (out_free) begin
            second        <= 1'b0;
            state         <= S_IDLE;
            if (v_lower) begin
              ref_x         <= px;
              ref_y         <= py;
              ref_speed     <= {1'b0, v_sat};
              ref_accel_mag <= {1'b0, a_mag};
              results.speed_out   <= {1'b0, v_sat};
              results.accel_out   <= SPEED_W'(-{1'b0, a_mag});
              results.was_updated <= 1'b1;
            end else begin
              pass_active         <= 1'b0;
              results.speed_out   <= spd;
              results.accel_out   <= acc_in_hold;
              results.was_updated <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (points.valid && points.ready) acc_in_hold <= points.accel_in;
  end
endmodule
